### hw/rtl/etch_endpoint_detector_top_assert.svh
// Assertion macros of the endpoint detector checker.
`ifndef ETCH_ENDPOINT_DETECTOR_TOP_ASSERT_SVH
`define ETCH_ENDPOINT_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define EPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define EPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/epd_pkg.sv
// Shared constants, codes and control structs of the endpoint detector.
package epd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TICK_BITS   = 24;
  localparam int SUM_BITS    = SAMPLE_BITS + TICK_BITS;
  localparam int HUND_BITS   = 36;
  localparam int THR_BITS    = 18;
  localparam int CHG_BITS    = 17;
  localparam int SLOPE_BITS  = SAMPLE_BITS + 1;
  localparam int MODE_BITS   = 4;
  localparam int CNT_BITS    = $clog2(SUM_BITS);
  localparam int OUT_BITS    = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // Request kinds
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_ABORT = 2'd2;
  localparam logic [1:0] REQ_END   = 2'd3;

  // Run phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_DELAY  = 3'd1;
  localparam logic [2:0] PH_NORM   = 3'd2;
  localparam logic [2:0] PH_CHANGE = 3'd3;
  localparam logic [2:0] PH_SLOPE  = 3'd4;

  // Run status
  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_DETECT  = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_EARLY   = 3'd3;
  localparam logic [2:0] ST_ABORT   = 3'd4;
  localparam logic [2:0] ST_ENDED   = 3'd5;

  // Register indexes
  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_DELAY = 3'd1;
  localparam logic [2:0] CFG_NORM  = 3'd2;
  localparam logic [2:0] CFG_CHG   = 3'd3;
  localparam logic [2:0] CFG_LIMIT = 3'd4;
  localparam logic [2:0] CFG_VALID = 3'd5;
  localparam logic [2:0] CFG_MIN   = 3'd6;
  localparam logic [2:0] CFG_MAX   = 3'd7;

  // Slope directions
  localparam logic [2:0] DIR_UP     = 3'd0;
  localparam logic [2:0] DIR_DOWN   = 3'd1;
  localparam logic [2:0] DIR_FLAT   = 3'd2;
  localparam logic [2:0] DIR_UPFLAT = 3'd3;
  localparam logic [2:0] DIR_DNFLAT = 3'd4;

  localparam logic [MODE_BITS-1:0] MODE_VALUE   = 4'd0;
  localparam logic [MODE_BITS-1:0] MODE_PERCENT = 4'd1;
  localparam logic [MODE_BITS-1:0] MODE_VSLOPE  = 4'd2;
  localparam logic [MODE_BITS-1:0] MODE_PSLOPE  = 4'd7;
  localparam logic [MODE_BITS-1:0] MODE_LAST    = 4'd11;

  typedef struct packed {
    logic in_load;
    logic step;
    logic div_start;
    logic div_thr;
    logic base_load;
    logic mul_en;
    logic thr_load;
    logic out_load;
  } epd_cmd_t;

  typedef struct packed {
    logic go_base;
    logic go_thr;
    logic div_done;
    logic out_free;
  } epd_stat_t;

endpackage

### hw/rtl/etch_endpoint_detector_top.sv
// Etch endpoint detector: run sequencing of delay, baseline, change and slope.
//
// Input channel in_*: in_tuser carries the request kind (start, sample tick,
// abort, end), in_tdata the 16-bit sample. Every accepted request yields
// exactly one result on out_* with status, phase, baseline, threshold and
// slope. Registers are written through cfg_* (index, data); the user must
// write them only while idle, as the block does not enforce it. cfg_ready
// is always high. An ordinary request passes the step, decide and output
// hand-off states. The sample that closes the normalize window also runs a
// restoring division for the baseline, one multiply for the threshold in
// hundredths and one reciprocal multiply for its floor. A run whose window
// is empty skips the division at the threshold step.
// One request is worked on at a time; in_tready rises again as soon as the
// result sits in the output register, so the next request can be taken
// while that result waits on out_tready. A stalled receiver holds the result
// and, once the next result is ready, holds the sequencer too.
// Reset (rst_n low, synchronous) returns registers to their defaults, the
// run to idle and empties the output register.
module etch_endpoint_detector_top import epd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [15:0]              in_tdata,   // [15:0] sample_value
  input  logic [1:0]               in_tuser,   // [1:0] req_type
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [2:0] run_status, [5:3] run_phase, [21:6] baseline_value,
  // [39:22] threshold, [56:40] current_slope, rest zero
  output logic [OUT_BITS-1:0]      out_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  epd_cmd_t  cmd;
  epd_stat_t stat;

  assign cfg_ready = 1'b1;

  epd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  epd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_req    (in_tuser),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

### hw/rtl/epd_div.sv
// Restoring divider, one quotient bit per cycle.
module epd_div import epd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SUM_BITS-1:0]  dividend,
  input  logic [TICK_BITS-1:0] divisor,
  output logic                 done,
  output logic [SUM_BITS-1:0]  quotient
);

  logic [TICK_BITS-1:0] rem_r;
  logic [TICK_BITS-1:0] dvs_r;
  logic [SUM_BITS-1:0]  quo_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [TICK_BITS:0]   shifted;
  logic [TICK_BITS+1:0] diff;
  logic                 fits;

  // Trial subtract of the shifted remainder
  assign shifted = {rem_r, quo_r[SUM_BITS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = !diff[TICK_BITS+1];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(SUM_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[TICK_BITS-1:0] : shifted[TICK_BITS-1:0];
      quo_r <= {quo_r[SUM_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hw/rtl/epd_ctrl.sv
// Sequencer of the endpoint detector: steps, divisions and result hand-off.
module epd_ctrl import epd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  epd_stat_t stat,
  output epd_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STEP   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_BDIV   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_TSTART = 3'd5;
  localparam logic [2:0] S_TDIV   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.go_base) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_BDIV;
        end else if (stat.go_thr) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_BDIV: begin
        if (stat.div_done) begin
          cmd.base_load = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_TSTART;
      end
      S_TSTART: begin
        cmd.div_thr = 1'b1;
        state_nxt   = S_TDIV;
      end
      S_TDIV: begin
        cmd.thr_load = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/epd_dp.sv
// Datapath: run state, configuration, threshold math and result register.
module epd_dp import epd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  epd_cmd_t                 cmd,
  output epd_stat_t                stat,
  input  logic [1:0]               in_req,
  input  logic [SAMPLE_BITS-1:0]   in_sample,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_BITS-1:0]      out_data
);

  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
  localparam logic signed [THR_BITS-1:0] THR_MAX = {1'b0, {(THR_BITS-1){1'b1}}};
  localparam logic signed [THR_BITS-1:0] THR_MIN = {1'b1, {(THR_BITS-1){1'b0}}};
  // Hundredths at which the floored threshold leaves the output range
  localparam logic [HUND_BITS-1:0] HUND_SAT = HUND_BITS'(100 * (1 << (THR_BITS - 1)));
  // ceil(2^31 / 100): exact floor of x / 100 for any x below 2^24
  localparam int               MAG_BITS    = 24;
  localparam int               RECIP_BITS  = 25;
  localparam int               RECIP_SHIFT = 31;
  localparam logic [RECIP_BITS-1:0] RECIP_100 = 25'd21474837;

  // Configuration
  logic [MODE_BITS-1:0]   mode_cfg_r;
  logic [TICK_BITS-1:0]   delay_r, norm_r, valid_r, min_r, max_r;
  logic [CHG_BITS-1:0]    chg_r;
  logic [SAMPLE_BITS-1:0] limit_r;

  // Run state
  logic [1:0]                   req_r;
  logic [SAMPLE_BITS-1:0]       smp_r;
  logic [2:0]                   phase_r, phase_nxt;
  logic [2:0]                   status_r, status_nxt;
  logic [MODE_BITS-1:0]         mode_r, mode_nxt;
  logic [TICK_BITS-1:0]         elapsed_r, elapsed_nxt;
  logic [TICK_BITS-1:0]         pticks_r, pticks_nxt;
  logic [TICK_BITS-1:0]         qual_r, qual_nxt;
  logic [SUM_BITS-1:0]          sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0]       base_r, base_nxt;
  logic signed [THR_BITS-1:0]   thr_r, thr_nxt;
  logic signed [HUND_BITS-1:0]  hund_r, hund_nxt;
  logic                         rise_r, rise_nxt;
  logic [SAMPLE_BITS-1:0]       prev_r, prev_nxt;
  logic                         seeded_r, seeded_nxt;
  logic signed [SLOPE_BITS-1:0] slope_r, slope_nxt;
  logic                         go_base_r, go_base_nxt;
  logic                         go_thr_r, go_thr_nxt;
  logic                         out_valid_r;
  logic [OUT_BITS-1:0]          out_data_r;
  logic [THR_BITS-2:0]          thr_q_r;
  logic                         thr_big_r;

  // Helpers
  logic [TICK_BITS-1:0]         elapsed_inc, pticks_inc, qual_inc, qual_new, need_valid;
  logic                         is_percent, dir_ok;
  logic [2:0]                   dir;
  logic signed [HUND_BITS-1:0]  scaled;
  logic                         hit_change, hit_slope;
  logic signed [SLOPE_BITS-1:0] slope_calc;
  logic signed [THR_BITS-1:0]   slope_w, limit_w;
  logic signed [THR_BITS-1:0]   chg_w, op_a, op_b;
  logic                         hund_neg;
  logic [SUM_BITS-1:0]          div_dividend, div_q;
  logic [TICK_BITS-1:0]         div_divisor;
  logic                         div_done;
  logic [HUND_BITS-1:0]         thr_mag;
  logic                         thr_big;
  logic [MAG_BITS+RECIP_BITS-1:0] thr_prod;
  logic signed [THR_BITS-1:0]   thr_sat;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_cfg_r <= '0;
      delay_r    <= '0;
      norm_r     <= '0;
      chg_r      <= '0;
      limit_r    <= '0;
      valid_r    <= TICK_BITS'(1);
      min_r      <= '0;
      max_r      <= TICK_MAX;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MODE:  mode_cfg_r <= cfg_wdata[MODE_BITS-1:0];
        CFG_DELAY: delay_r    <= cfg_wdata[TICK_BITS-1:0];
        CFG_NORM:  norm_r     <= cfg_wdata[TICK_BITS-1:0];
        CFG_CHG:   chg_r      <= cfg_wdata[CHG_BITS-1:0];
        CFG_LIMIT: limit_r    <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_VALID: valid_r    <= cfg_wdata[TICK_BITS-1:0];
        CFG_MIN:   min_r      <= cfg_wdata[TICK_BITS-1:0];
        CFG_MAX:   max_r      <= cfg_wdata[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Saturating counters
  assign elapsed_inc = (elapsed_r == TICK_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign pticks_inc  = (pticks_r == TICK_MAX) ? pticks_r : pticks_r + 1'b1;
  assign qual_inc    = (qual_r == TICK_MAX) ? qual_r : qual_r + 1'b1;
  assign need_valid  = (valid_r == '0) ? TICK_BITS'(1) : valid_r;

  // Mode decode
  assign is_percent = (mode_r == MODE_PERCENT) ||
                      (mode_r >= MODE_PSLOPE && mode_r <= MODE_LAST);
  always_comb begin
    dir_ok = 1'b0;
    dir    = DIR_UP;
    if (mode_r >= MODE_VSLOPE && mode_r < MODE_PSLOPE) begin
      dir_ok = 1'b1;
      dir    = 3'(mode_r - MODE_VSLOPE);
    end else if (mode_r >= MODE_PSLOPE && mode_r <= MODE_LAST) begin
      dir_ok = 1'b1;
      dir    = 3'(mode_r - MODE_PSLOPE);
    end
  end

  // Change compare in hundredths: sample * 100 as shifts and adds
  assign scaled = $signed({{(HUND_BITS-SAMPLE_BITS){1'b0}}, smp_r} << 6)
                + $signed({{(HUND_BITS-SAMPLE_BITS){1'b0}}, smp_r} << 5)
                + $signed({{(HUND_BITS-SAMPLE_BITS){1'b0}}, smp_r} << 2);
  assign hit_change = rise_r ? (scaled >= hund_r) : (scaled <= hund_r);

  // Slope compare
  assign slope_calc = $signed({1'b0, smp_r}) - $signed({1'b0, prev_r});
  assign slope_w    = THR_BITS'(slope_calc);
  assign limit_w    = $signed({2'b00, limit_r});
  always_comb begin
    unique case (dir)
      DIR_UP:     hit_slope = slope_w > limit_w;
      DIR_DOWN:   hit_slope = slope_w < -limit_w;
      DIR_FLAT:   hit_slope = slope_w <= limit_w;
      DIR_UPFLAT: hit_slope = (slope_w > 0) && (slope_w <= limit_w);
      default:    hit_slope = (slope_w < 0) && (slope_w <= limit_w);
    endcase
  end

  assign qual_new = (phase_r == PH_CHANGE) ? (hit_change ? qual_inc : '0)
                                           : (hit_slope ? qual_inc : '0);

  // Threshold multiply operands
  assign chg_w = THR_BITS'($signed(chg_r));
  assign op_a  = is_percent ? $signed({2'b00, base_r}) : $signed({2'b00, base_r}) + chg_w;
  assign op_b  = is_percent ? THR_BITS'(100) + chg_w : THR_BITS'(100);

  // Baseline divider: rounded average of the window
  assign div_dividend = sum_r + SUM_BITS'(pticks_r >> 1);
  assign div_divisor  = pticks_r;

  epd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Floor of hundredths: magnitude (rounded up when negative), reciprocal multiply
  assign hund_neg = hund_r[HUND_BITS-1];
  assign thr_mag  = hund_neg ? unsigned'(-hund_r) + HUND_BITS'(99) : unsigned'(hund_r);
  assign thr_big  = (thr_mag >= HUND_SAT);
  assign thr_prod = thr_mag[MAG_BITS-1:0] * RECIP_100;

  always_ff @(posedge clk) begin
    if (cmd.div_thr) begin
      thr_q_r   <= thr_prod[RECIP_SHIFT +: THR_BITS-1];
      thr_big_r <= thr_big;
    end
  end

  // Saturate floor quotient into the threshold range
  always_comb begin
    if (thr_big_r) begin
      thr_sat = hund_neg ? THR_MIN : THR_MAX;
    end else if (hund_neg) begin
      thr_sat = -$signed({1'b0, thr_q_r});
    end else begin
      thr_sat = $signed({1'b0, thr_q_r});
    end
  end

  // Next run state
  always_comb begin
    phase_nxt   = phase_r;
    status_nxt  = status_r;
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    pticks_nxt  = pticks_r;
    qual_nxt    = qual_r;
    sum_nxt     = sum_r;
    base_nxt    = base_r;
    thr_nxt     = thr_r;
    hund_nxt    = hund_r;
    rise_nxt    = rise_r;
    prev_nxt    = prev_r;
    seeded_nxt  = seeded_r;
    slope_nxt   = slope_r;
    go_base_nxt = go_base_r;
    go_thr_nxt  = go_thr_r;
    if (cmd.step) begin
      status_nxt  = ST_RUN;
      slope_nxt   = '0;
      go_base_nxt = 1'b0;
      go_thr_nxt  = 1'b0;
      unique case (req_r)
        REQ_START: begin
          mode_nxt    = (mode_cfg_r > MODE_LAST) ? MODE_VALUE : mode_cfg_r;
          elapsed_nxt = '0;
          pticks_nxt  = '0;
          sum_nxt     = '0;
          base_nxt    = '0;
          thr_nxt     = '0;
          qual_nxt    = '0;
          prev_nxt    = '0;
          seeded_nxt  = 1'b0;
          hund_nxt    = '0;
          rise_nxt    = 1'b1;
          phase_nxt   = PH_DELAY;
          if (delay_r == '0) begin
            phase_nxt = PH_NORM;
            if (norm_r == '0) go_thr_nxt = 1'b1;
          end
        end
        REQ_ABORT, REQ_END: begin
          if (phase_r != PH_IDLE) begin
            status_nxt = (req_r == REQ_ABORT) ? ST_ABORT : ST_ENDED;
            phase_nxt  = PH_IDLE;
          end
        end
        default: begin
          unique case (phase_r)
            PH_DELAY: begin
              elapsed_nxt = elapsed_inc;
              pticks_nxt  = pticks_inc;
              if (pticks_inc >= delay_r) begin
                phase_nxt  = PH_NORM;
                pticks_nxt = '0;
                sum_nxt    = '0;
                if (norm_r == '0) begin
                  base_nxt   = '0;
                  go_thr_nxt = 1'b1;
                end
              end
            end
            PH_NORM: begin
              elapsed_nxt = elapsed_inc;
              pticks_nxt  = pticks_inc;
              sum_nxt     = sum_r + SUM_BITS'(smp_r);
              if (pticks_inc >= norm_r) go_base_nxt = 1'b1;
            end
            PH_CHANGE, PH_SLOPE: begin
              if (elapsed_r >= max_r) begin
                status_nxt = ST_TIMEOUT;
                phase_nxt  = PH_IDLE;
              end else begin
                elapsed_nxt = elapsed_inc;
                if (phase_r == PH_SLOPE && !seeded_r) begin
                  prev_nxt   = smp_r;
                  seeded_nxt = 1'b1;
                end else begin
                  if (phase_r == PH_SLOPE) begin
                    slope_nxt = slope_calc;
                    prev_nxt  = smp_r;
                  end
                  qual_nxt = qual_new;
                  if (qual_new >= ((phase_r == PH_CHANGE && is_percent) ?
                                   TICK_BITS'(2) : need_valid)) begin
                    if (elapsed_inc < min_r) begin
                      phase_nxt  = PH_IDLE;
                      status_nxt = ST_EARLY;
                    end else if (phase_r == PH_CHANGE && dir_ok) begin
                      phase_nxt  = PH_SLOPE;
                      qual_nxt   = '0;
                      seeded_nxt = 1'b0;
                      pticks_nxt = '0;
                    end else begin
                      phase_nxt  = PH_IDLE;
                      status_nxt = ST_DETECT;
                    end
                  end
                end
              end
            end
            default: ;
          endcase
        end
      endcase
    end
    if (cmd.base_load) base_nxt = div_q[SAMPLE_BITS-1:0];
    if (cmd.mul_en) begin
      hund_nxt = op_a * op_b;
      rise_nxt = !chg_r[CHG_BITS-1];
    end
    if (cmd.thr_load) begin
      thr_nxt    = thr_sat;
      qual_nxt   = '0;
      pticks_nxt = '0;
      phase_nxt  = PH_CHANGE;
    end
  end

  // Run state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      status_r  <= ST_RUN;
      mode_r    <= MODE_VALUE;
      elapsed_r <= '0;
      pticks_r  <= '0;
      qual_r    <= '0;
      sum_r     <= '0;
      base_r    <= '0;
      thr_r     <= '0;
      hund_r    <= '0;
      rise_r    <= 1'b1;
      prev_r    <= '0;
      seeded_r  <= 1'b0;
      slope_r   <= '0;
      go_base_r <= 1'b0;
      go_thr_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      status_r  <= status_nxt;
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      pticks_r  <= pticks_nxt;
      qual_r    <= qual_nxt;
      sum_r     <= sum_nxt;
      base_r    <= base_nxt;
      thr_r     <= thr_nxt;
      hund_r    <= hund_nxt;
      rise_r    <= rise_nxt;
      prev_r    <= prev_nxt;
      seeded_r  <= seeded_nxt;
      slope_r   <= slope_nxt;
      go_base_r <= go_base_nxt;
      go_thr_r  <= go_thr_nxt;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      req_r <= in_req;
      smp_r <= in_sample;
    end
  end

  // Result register: load on hand-off, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= OUT_BITS'({slope_r, thr_r, base_r, phase_r, status_r});
    end
  end

  assign stat.go_base  = go_base_r;
  assign stat.go_thr   = go_thr_r;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

### hw/rtl/epd_checker.sv
// Port-level checks of the endpoint detector, bound to the top level.
`include "etch_endpoint_detector_top_assert.svh"

module epd_checker import epd_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic [15:0]              in_tdata,
  input logic [1:0]               in_tuser,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_BITS-1:0]      out_tdata,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic [CFG_IDX_BITS-1:0]  cfg_index,
  input logic [CFG_DATA_BITS-1:0] cfg_data
);

  // Stalled result holds
  `EPD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  // One request at a time
  `EPD_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "request taken while busy")

  // A final status always closes the run
  `EPD_ASSERT_NOW(a_end_idle, out_tvalid && out_tdata[2:0] != ST_RUN, out_tdata[5:3] == PH_IDLE, "run not idle after final status")

  // Slope shows only in the slope phase or at the step that ends it
  `EPD_ASSERT_NOW(a_slope_zero, out_tvalid && out_tdata[2:0] == ST_RUN && out_tdata[5:3] != PH_SLOPE, out_tdata[56:40] == '0, "slope outside slope phase")

endmodule

bind etch_endpoint_detector_top epd_checker u_epd_checker (.*);

### tb/etch_endpoint_detector_top_tb.sv
// Self-checking testbench of the etch endpoint detector with a built-in run predictor.
`timescale 1ns / 1ps

module etch_endpoint_detector_top_tb;
  import epd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  // Lowest field last: matches the packing of out_tdata
  typedef struct packed {
    logic [16:0] slope;
    logic [17:0] threshold;
    logic [15:0] baseline;
    logic [2:0]  phase;
    logic [2:0]  status;
  } epd_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  etch_endpoint_detector_top DUT (.*);

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor copies of registers and run state
  logic [3:0]  r_mode;
  logic [23:0] r_delay, r_norm, r_valid, r_min, r_max;
  logic [16:0] r_chg;
  logic [15:0] r_limit;
  logic [2:0]  p_phase;
  logic [23:0] p_elapsed, p_phase_ticks, p_qual;
  logic [39:0] p_sum;
  logic [15:0] p_base, p_prev;
  logic signed [17:0] p_thr;
  logic p_seeded, p_rise;
  logic [3:0] p_mode;
  longint p_hund;

  epd_result_t expected_results[$];
  int mismatches = 0;
  int n_results = 0;
  bit stall_en = 1'b1;
  bit idle_en = 1'b1;
  int quiet_cycles = 0;

  function automatic logic [23:0] sat_inc(logic [23:0] v);
    return (v == 24'hFFFFFF) ? v : v + 24'd1;
  endfunction

  function automatic bit is_percent_mode();
    return p_mode == MODE_PERCENT || (p_mode >= MODE_PSLOPE && p_mode <= MODE_LAST);
  endfunction

  function automatic int slope_direction();
    if (p_mode >= MODE_VSLOPE && p_mode < MODE_PSLOPE) return int'(p_mode - MODE_VSLOPE);
    if (p_mode >= MODE_PSLOPE && p_mode <= MODE_LAST) return int'(p_mode - MODE_PSLOPE);
    return -1;
  endfunction

  function automatic logic [23:0] need_valid();
    return (r_valid == 0) ? 24'd1 : r_valid;
  endfunction

  function automatic void reset_model();
    r_mode = MODE_VALUE; r_delay = 0; r_norm = 0; r_chg = 0; r_limit = 0;
    r_valid = 1; r_min = 0; r_max = 24'hFFFFFF;
    p_phase = PH_IDLE; p_elapsed = 0; p_phase_ticks = 0; p_sum = 0; p_base = 0;
    p_thr = 0; p_qual = 0; p_prev = 0; p_seeded = 0; p_mode = MODE_VALUE;
    p_hund = 0; p_rise = 1;
  endfunction

  function automatic void begin_change_phase();
    longint chg, fl;
    chg = longint'($signed(r_chg));
    if (is_percent_mode()) p_hund = longint'(p_base) * (100 + chg);
    else p_hund = (longint'(p_base) + chg) * 100;
    p_rise = chg >= 0;
    fl = (p_hund >= 0) ? p_hund / 100 : -((-p_hund + 99) / 100);
    if (fl > 131071) fl = 131071;
    if (fl < -131072) fl = -131072;
    p_thr = fl[17:0];
    p_qual = 0; p_phase_ticks = 0; p_phase = PH_CHANGE;
  endfunction

  function automatic void begin_baseline_phase();
    p_phase = PH_NORM; p_phase_ticks = 0; p_sum = 0;
    if (r_norm == 0) begin
      p_base = 0;
      begin_change_phase();
    end
  endfunction

  function automatic logic [2:0] close_success(bit to_slope);
    if (p_elapsed < r_min) begin
      p_phase = PH_IDLE;
      return ST_EARLY;
    end
    if (to_slope) begin
      p_phase = PH_SLOPE; p_qual = 0; p_seeded = 0; p_phase_ticks = 0;
      return ST_RUN;
    end
    p_phase = PH_IDLE;
    return ST_DETECT;
  endfunction

  function automatic bit slope_qualifies(longint s);
    longint lim;
    lim = longint'(r_limit);
    case (slope_direction())
      DIR_UP:     return s > lim;
      DIR_DOWN:   return s < -lim;
      DIR_FLAT:   return s <= lim;
      DIR_UPFLAT: return s > 0 && s <= lim;
      default:    return s < 0 && s <= lim;
    endcase
  endfunction

  // Advance the predicted run by one request and return the expected result
  function automatic epd_result_t predict_run_step(logic [1:0] req, logic [15:0] smp);
    epd_result_t r;
    logic [2:0] st;
    longint slope;
    bit hit;
    logic [23:0] need;
    st = ST_RUN; slope = 0;
    if (req == REQ_START) begin
      p_mode = (r_mode > MODE_LAST) ? MODE_VALUE : r_mode;
      p_elapsed = 0; p_phase_ticks = 0; p_sum = 0; p_base = 0; p_thr = 0;
      p_qual = 0; p_prev = 0; p_seeded = 0; p_hund = 0; p_rise = 1;
      p_phase = PH_DELAY;
      if (r_delay == 0) begin_baseline_phase();
    end else if (req == REQ_ABORT || req == REQ_END) begin
      if (p_phase != PH_IDLE) begin
        st = (req == REQ_ABORT) ? ST_ABORT : ST_ENDED;
        p_phase = PH_IDLE;
      end
    end else if (p_phase == PH_DELAY) begin
      p_elapsed = sat_inc(p_elapsed);
      p_phase_ticks = sat_inc(p_phase_ticks);
      if (p_phase_ticks >= r_delay) begin_baseline_phase();
    end else if (p_phase == PH_NORM) begin
      p_elapsed = sat_inc(p_elapsed);
      p_phase_ticks = sat_inc(p_phase_ticks);
      p_sum = p_sum + smp;
      if (p_phase_ticks >= r_norm) begin
        p_base = 16'((p_sum + (p_phase_ticks >> 1)) / p_phase_ticks);
        begin_change_phase();
      end
    end else if (p_phase == PH_CHANGE || p_phase == PH_SLOPE) begin
      if (p_elapsed >= r_max) begin
        st = ST_TIMEOUT;
        p_phase = PH_IDLE;
      end else begin
        p_elapsed = sat_inc(p_elapsed);
        if (p_phase == PH_CHANGE) begin
          need = is_percent_mode() ? 24'd2 : need_valid();
          hit = p_rise ? (longint'(smp) * 100 >= p_hund) : (longint'(smp) * 100 <= p_hund);
          p_qual = hit ? sat_inc(p_qual) : 24'd0;
          if (p_qual >= need) st = close_success(slope_direction() >= 0);
        end else if (!p_seeded) begin
          p_prev = smp;
          p_seeded = 1;
        end else begin
          slope = longint'(smp) - longint'(p_prev);
          p_prev = smp;
          hit = slope_qualifies(slope);
          p_qual = hit ? sat_inc(p_qual) : 24'd0;
          if (p_qual >= need_valid()) st = close_success(1'b0);
        end
      end
    end
    r.status = st; r.phase = p_phase; r.baseline = p_base;
    r.threshold = p_thr; r.slope = slope[16:0];
    return r;
  endfunction

  // Receiver: random stall bursts, compare each transfer with the oldest expectation
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        out_tready <= 1'b0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    epd_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[56:0];
      n_results++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want || out_tdata[OUT_BITS-1:57] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d exp st=%0d ph=%0d base=%0d thr=%h slope=%h got st=%0d ph=%0d base=%0d thr=%h slope=%h",
                     n_results, want.status, want.phase, want.baseline, want.threshold, want.slope,
                     got.status, got.phase, got.baseline, got.threshold, got.slope);
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one request; transfer happens at the rising edge with tvalid and tready high.
  // Leave tvalid high at return: the next request drives it anew or a drain drops it.
  task automatic send_request(logic [1:0] req, logic [15:0] smp);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= smp;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_run_step(req, smp));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE:  r_mode = val[3:0];
      CFG_DELAY: r_delay = val;
      CFG_NORM:  r_norm = val;
      CFG_CHG:   r_chg = val[16:0];
      CFG_LIMIT: r_limit = val[15:0];
      CFG_VALID: r_valid = val;
      CFG_MIN:   r_min = val;
      default:   r_max = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [3:0] mode, logic [23:0] dly, logic [23:0] nrm,
                           logic [16:0] chg, logic [15:0] lim, logic [23:0] vld,
                           logic [23:0] tmin, logic [23:0] tmax);
    drain_results();
    write_register(CFG_MODE, 24'(mode));
    write_register(CFG_DELAY, dly);
    write_register(CFG_NORM, nrm);
    write_register(CFG_CHG, 24'(chg));
    write_register(CFG_LIMIT, 24'(lim));
    write_register(CFG_VALID, vld);
    write_register(CFG_MIN, tmin);
    write_register(CFG_MAX, tmax);
  endtask

  // Requests while idle: tick, abort and end, sample extremes
  task automatic test_idle_requests();
    send_request(REQ_TICK, 16'hFFFF);
    send_request(REQ_ABORT, 16'h0000);
    send_request(REQ_END, 16'hAAAA);
  endtask

  // Value change with zero delay and empty window, an abort, a percent run closed by end, a mode beyond the last
  task automatic test_directed_runs();
    configure(MODE_VALUE, 0, 0, 17'd5, 0, 0, 0, 24'hFFFFFF);
    send_request(REQ_START, 0);
    send_request(REQ_TICK, 16'd4);
    send_request(REQ_TICK, 16'hFFFF);
    send_request(REQ_START, 0);
    send_request(REQ_ABORT, 0);
    configure(MODE_PERCENT, 2, 3, -17'sd65535, 16'hFFFF, 24'hFFFFFF, 5, 24'd20);
    send_request(REQ_START, 0);
    for (int i = 0; i < 6; i++) send_request(REQ_TICK, 16'(16'hFFFF - i));
    send_request(REQ_TICK, 16'd0);
    send_request(REQ_TICK, 16'd0);
    send_request(REQ_END, 0);
    configure(4'd15, 0, 1, 17'd65535, 0, 1, 0, 0);
    send_request(REQ_START, 0);
    send_request(REQ_TICK, 16'hFFFF);
    send_request(REQ_TICK, 16'hFFFF);
    send_request(REQ_START, 0);
  endtask

  // One random run: mostly complete start/tick sequences, some noise
  task automatic random_run(int ticks);
    logic [15:0] v;
    int step;
    v = 16'($urandom);
    step = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 300);
    send_request(REQ_START, 16'($urandom));
    for (int i = 0; i < ticks; i++) begin
      case ($urandom_range(0, 9))
        0: v = 16'($urandom);
        1, 2: v = v - 16'(step);
        3, 4, 5: v = v + 16'(step);
        default: v = v + 16'($urandom_range(0, 8)) - 16'd4;
      endcase
      if ($urandom_range(0, 60) == 0)
        send_request($urandom_range(0, 1) ? REQ_ABORT : REQ_END, 16'($urandom));
      else
        send_request(REQ_TICK, v);
    end
  endtask

  task automatic test_random_runs(int n_items);
    int sent, ticks;
    int chg;
    sent = 0;
    while (sent < n_items) begin
      chg = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131070) - 65535
                                       : $urandom_range(0, 600) - 300;
      configure(4'($urandom_range(0, 15)), 24'($urandom_range(0, 4)),
                $urandom_range(0, 9) == 0 ? 24'($urandom_range(20, 40))
                                          : 24'($urandom_range(0, 5)),
                17'(chg), $urandom_range(0, 9) == 0 ? 16'hFFFF : 16'($urandom_range(0, 200)),
                24'($urandom_range(0, 4)),
                $urandom_range(0, 3) == 0 ? 24'($urandom_range(0, 30)) : 24'd0,
                $urandom_range(0, 3) == 0 ? 24'($urandom_range(0, 60)) : 24'hFFFFFF);
      ticks = $urandom_range(10, 60);
      random_run(ticks);
      sent += ticks + 1;
      if (sent > n_items * 3 / 4) begin
        idle_en = 1'b0;
        stall_en = 1'b0;
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_idle_requests();
    test_directed_runs();
    test_random_runs(1700);
    drain_results();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
